>>> design/lcps_pkg.sv
// shared types and constants of the led chase pattern sequencer
`default_nettype none

package lcps_pkg;

    localparam int LED_COUNT = 9;
    localparam int LED_W     = LED_COUNT;
    localparam logic [3:0] LED_LAST = 4'(LED_COUNT - 1);

    // chase bases inside the led vector
    localparam logic [3:0] RED_BASE   = 4'd0;
    localparam logic [3:0] GREEN_BASE = 4'd3;
    localparam logic [3:0] BLUE_BASE  = 4'd6;

    // blue pass ends when the step counter reaches this value
    localparam logic [3:0] BLUE_END_STEP = 4'd3;

    localparam logic [7:0] SLOW_PERIOD_RST  = 8'd50;
    localparam logic [7:0] FAST_PERIOD_RST  = 8'd10;
    localparam logic [7:0] TICKS_PER_S_RST  = 8'd100;
    localparam logic [7:0] RGB_HOLD_RST     = 8'd30;
    localparam logic [7:0] GREEN_HOLD_RST   = 8'd5;
    localparam logic [3:0] BLUE_LIMIT_RST   = 4'd10;

    typedef enum logic [2:0] {
        MODE_OFF   = 3'd0,
        MODE_RGB   = 3'd1,
        MODE_GREEN = 3'd2,
        MODE_BLUE  = 3'd3,
        MODE_RED   = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        CFG_SLOW_PERIOD  = 3'd0,
        CFG_FAST_PERIOD  = 3'd1,
        CFG_TICKS_PER_S  = 3'd2,
        CFG_RGB_HOLD     = 3'd3,
        CFG_GREEN_HOLD   = 3'd4,
        CFG_BLUE_LIMIT   = 3'd5
    } cfg_index_t;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic [7:0] slow_period;
        logic [7:0] fast_period;
        logic [7:0] ticks_per_second;
        logic [7:0] rgb_hold_seconds;
        logic [7:0] green_hold_seconds;
        logic [3:0] blue_pass_limit;
    } cfg_t;

    typedef struct packed {
        mode_t            mode;
        logic             init_pending;
        logic [7:0]       step_ticks;
        logic [3:0]       chase_step;
        logic [7:0]       hold_ticks;
        logic [7:0]       hold_seconds;
        logic [3:0]       blue_passes;
        logic [LED_W-1:0] leds;
    } state_t;

    typedef struct packed {
        logic [LED_W-1:0] led_pins;
        logic [2:0]       mode_now;
        logic             net_change_clear;
        logic             mode_buffer_clear;
    } result_t;

endpackage : lcps_pkg

`default_nettype wire

>>> design/led_chase_pattern_sequencer_unit.sv
// LED chase pattern sequencer: one request is a tick or a mode write, each gives one result.
// A request moves through an input register and then a result register, and one request per
// cycle is taken for as long as the result side does not stall. The sequencer state (mode,
// counters, leds) is updated in the cycle a request leaves the input register, by the single
// pass of lcps_step. A stall on the output holds the result register and backs up into the
// input register and then in_stall. The user must write configuration through cfg_write_en,
// cfg_index and cfg_data only while no request is in flight; the block itself does not enforce
// this. Out-of-range indexes are dropped.
`default_nettype none

module led_chase_pattern_sequencer_unit
    import lcps_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic             command,
    input  wire logic [2:0]       new_mode,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [LED_W-1:0]      led_pins,
    output logic [2:0]            mode_now,
    output logic                  net_change_clear,
    output logic                  mode_buffer_clear,
    input  wire logic             cfg_write_en,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [7:0]       cfg_data
);

    cfg_t       cfg_reg;
    state_t     state_reg;
    state_t     state_next;
    result_t    res_next;
    result_t    res_reg;
    logic       s1_valid_reg;
    logic       s1_cmd_reg;
    logic [2:0] s1_mode_reg;
    logic       out_valid_reg;
    logic       advance;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slow_period        <= SLOW_PERIOD_RST;
            cfg_reg.fast_period        <= FAST_PERIOD_RST;
            cfg_reg.ticks_per_second   <= TICKS_PER_S_RST;
            cfg_reg.rgb_hold_seconds   <= RGB_HOLD_RST;
            cfg_reg.green_hold_seconds <= GREEN_HOLD_RST;
            cfg_reg.blue_pass_limit    <= BLUE_LIMIT_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_SLOW_PERIOD: cfg_reg.slow_period        <= cfg_data;
                CFG_FAST_PERIOD: cfg_reg.fast_period        <= cfg_data;
                CFG_TICKS_PER_S: cfg_reg.ticks_per_second   <= cfg_data;
                CFG_RGB_HOLD:    cfg_reg.rgb_hold_seconds   <= cfg_data;
                CFG_GREEN_HOLD:  cfg_reg.green_hold_seconds <= cfg_data;
                CFG_BLUE_LIMIT:  cfg_reg.blue_pass_limit    <= cfg_data[3:0];
                default:         cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_cmd_reg  <= command;
            s1_mode_reg <= new_mode;
        end
    end

    lcps_step u_step (
        .cur      (state_reg),
        .cfg      (cfg_reg),
        .command  (s1_cmd_reg),
        .new_mode (s1_mode_reg),
        .nxt      (state_next),
        .res      (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode         <= MODE_OFF;
            state_reg.init_pending <= 1'b1;
            state_reg.step_ticks   <= '0;
            state_reg.chase_step   <= '0;
            state_reg.hold_ticks   <= '0;
            state_reg.hold_seconds <= '0;
            state_reg.blue_passes  <= '0;
            state_reg.leds         <= '0;
            out_valid_reg          <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign led_pins          = res_reg.led_pins;
    assign mode_now          = res_reg.mode_now;
    assign net_change_clear  = res_reg.net_change_clear;
    assign mode_buffer_clear = res_reg.mode_buffer_clear;

    // a clear pulse always comes with the fall back to off
    a_clear_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (net_change_clear || mode_buffer_clear) |-> mode_now == MODE_OFF)
        else $error("clear pulse without off mode");

    a_clear_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(net_change_clear && mode_buffer_clear))
        else $error("both clear pulses in one result");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.chase_step <= LED_LAST)
        else $error("chase step out of range");

    a_request_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("request lost between input and result register");

endmodule : led_chase_pattern_sequencer_unit

`default_nettype wire

>>> design/lcps_step.sv
// next-state and result logic for one request of the led chase sequencer
`default_nettype none

module lcps_step
    import lcps_pkg::*;
(
    input  wire state_t     cur,
    input  wire cfg_t       cfg,
    input  wire logic       command,
    input  wire logic [2:0] new_mode,
    output state_t          nxt,
    output result_t         res
);

    function automatic logic [LED_W-1:0] light(
        input logic [LED_W-1:0] leds,
        input logic [3:0]       prev_idx,
        input logic [3:0]       cur_idx
    );
        logic [LED_W-1:0] v;
        v = leds & ~(LED_W'(1) << prev_idx);
        v = v | (LED_W'(1) << cur_idx);
        return v;
    endfunction

    function automatic state_t do_init(input state_t s);
        state_t v;
        v = s;
        v.init_pending = 1'b0;
        v.leds         = '0;
        v.step_ticks   = '0;
        v.chase_step   = '0;
        v.hold_ticks   = '0;
        v.hold_seconds = '0;
        return v;
    endfunction

    // second counter; on expiry the mode falls back to off
    function automatic state_t hold_advance(
        input state_t     s,
        input logic [7:0] secs,
        input logic [7:0] tps
    );
        state_t v;
        v = s;
        v.hold_ticks = v.hold_ticks + 8'd1;
        if (v.hold_ticks >= tps)
        begin
            v.hold_ticks   = '0;
            v.hold_seconds = v.hold_seconds + 8'd1;
            if (v.hold_seconds >= secs)
            begin
                v.hold_seconds = '0;
                v.mode         = MODE_OFF;
                v.init_pending = 1'b1;
            end
        end
        return v;
    endfunction

    // three-led chase at the fast period
    function automatic state_t chase_three(
        input state_t     s,
        input logic [7:0] period,
        input logic [3:0] base
    );
        state_t     v;
        logic [3:0] prev;
        v = s;
        v.step_ticks = v.step_ticks + 8'd1;
        if (v.step_ticks >= period)
        begin
            v.step_ticks = '0;
            v.chase_step = v.chase_step + 4'd1;
            if (v.chase_step > 4'd2)
            begin
                v.chase_step = '0;
            end
        end
        prev = (v.chase_step == 4'd0) ? 4'd2 : v.chase_step - 4'd1;
        if (v.chase_step <= 4'd2)
        begin
            v.leds = light(v.leds, base + prev, base + v.chase_step);
        end
        return v;
    endfunction

    state_t     w;
    logic [3:0] prev9;
    logic       net_clr;
    logic       buf_clr;

    always_comb
    begin
        w       = cur;
        net_clr = 1'b0;
        buf_clr = 1'b0;
        prev9   = '0;
        if (command == CMD_WRITE)
        begin
            if (new_mode <= 3'(MODE_RED))
            begin
                w.mode         = mode_t'(new_mode);
                w.init_pending = 1'b1;
            end
        end
        else
        begin
            unique case (w.mode)
                MODE_OFF:
                begin
                    if (w.init_pending)
                    begin
                        w.init_pending = 1'b0;
                        w.leds         = '0;
                    end
                end
                MODE_RGB:
                begin
                    if (w.init_pending)
                    begin
                        w = do_init(w);
                    end
                    w.step_ticks = w.step_ticks + 8'd1;
                    if (w.step_ticks >= cfg.slow_period)
                    begin
                        w.step_ticks = '0;
                        w.chase_step = w.chase_step + 4'd1;
                        if (w.chase_step > LED_LAST)
                        begin
                            w.chase_step = '0;
                        end
                    end
                    prev9 = (w.chase_step == 4'd0) ? LED_LAST : w.chase_step - 4'd1;
                    if (w.chase_step <= LED_LAST)
                    begin
                        w.leds = light(w.leds, prev9, w.chase_step);
                    end
                    w = hold_advance(w, cfg.rgb_hold_seconds, cfg.ticks_per_second);
                end
                MODE_GREEN:
                begin
                    if (w.init_pending)
                    begin
                        w = do_init(w);
                    end
                    w = chase_three(w, cfg.fast_period, GREEN_BASE);
                    w = hold_advance(w, cfg.green_hold_seconds, cfg.ticks_per_second);
                    // timeout is the only way out of green within a tick
                    net_clr = (w.mode == MODE_OFF);
                end
                MODE_BLUE:
                begin
                    if (w.init_pending)
                    begin
                        w             = do_init(w);
                        w.blue_passes = '0;
                    end
                    w.step_ticks = w.step_ticks + 8'd1;
                    if (w.step_ticks >= cfg.slow_period)
                    begin
                        w.step_ticks = '0;
                        w.chase_step = w.chase_step + 4'd1;
                    end
                    prev9 = (w.chase_step == 4'd0) ? 4'd2 : w.chase_step - 4'd1;
                    if (w.chase_step <= 4'd2)
                    begin
                        w.leds = light(w.leds, BLUE_BASE + prev9, BLUE_BASE + w.chase_step);
                    end
                    else if (w.chase_step == BLUE_END_STEP)
                    begin
                        w.chase_step   = '0;
                        w.mode         = MODE_OFF;
                        w.init_pending = 1'b1;
                        w.blue_passes  = w.blue_passes + 4'd1;
                        if (w.blue_passes >= cfg.blue_pass_limit)
                        begin
                            w.blue_passes = '0;
                            buf_clr       = 1'b1;
                        end
                    end
                end
                MODE_RED:
                begin
                    if (w.init_pending)
                    begin
                        w = do_init(w);
                    end
                    w = chase_three(w, cfg.fast_period, RED_BASE);
                end
                default:
                begin
                    w = cur;
                end
            endcase
        end
    end

    assign nxt                   = w;
    assign res.led_pins          = w.leds;
    assign res.mode_now          = w.mode;
    assign res.net_change_clear  = net_clr;
    assign res.mode_buffer_clear = buf_clr;

endmodule : lcps_step

`default_nettype wire
